[src/adc_to_control_change_deadband_top_defines.svh]
`ifndef ADC_TO_CONTROL_CHANGE_DEADBAND_TOP_DEFINES_SVH
`define ADC_TO_CONTROL_CHANGE_DEADBAND_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define ACTCD_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check an implication within the same cycle.
`define ACTCD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle.
`define ACTCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/actcd_pkg.sv]
`default_nettype none

package actcd_pkg;

  localparam int NUM_CONTROLS_DEF = 3;
  localparam int SAMPLE_BITS_DEF  = 12;

  localparam int LEVEL_W    = 7;
  localparam int COUNT_W    = 6;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]         STATUS_CC = 8'd176;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd127;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_RANGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_A       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_B       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_C       = 3'd6;

  // Register reset values
  localparam logic [6:0]  DEVIATION_RST    = 7'd2;
  localparam logic [5:0]  CLAMP_RST        = 6'd2;
  localparam logic [15:0] MIN_INTERVAL_RST = 16'd10;
  localparam logic [5:0]  EXTRA_RST        = 6'd20;
  localparam logic [6:0]  CTRL_A_RST       = 7'd1;
  localparam logic [6:0]  CTRL_B_RST       = 7'd2;
  localparam logic [6:0]  CTRL_C_RST       = 7'd3;

  // Control indexes that have a controller-number register
  localparam logic [1:0] CONTROL_A = 2'd0;
  localparam logic [1:0] CONTROL_B = 2'd1;
  localparam logic [1:0] CONTROL_C = 2'd2;

endpackage

`default_nettype wire

[src/actcd_ram.sv]
`default_nettype none

module actcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/adc_to_control_change_deadband_top.sv]
// A request accepted at the input is registered in the update stage; its message is then registered at the output.
// Throughput: one request per cycle while the output is not blocked, set by the single read-modify-write pass
// over the per-control state memory (one read port, one write port).
// Reset: synchronous, active low; loads register defaults, clears counter, stage and entry valid bits.
// No clearing pass: an entry not yet written reads as zero.
`default_nettype none

module adc_to_control_change_deadband_top #(
  parameter int NUM_CONTROLS = actcd_pkg::NUM_CONTROLS_DEF,
  parameter int SAMPLE_BITS  = actcd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_op,
  input  wire logic [1:0]                        in_control_index,
  input  wire logic [11:0]                       in_sample,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             out_status_byte,
  output logic [6:0]                             out_controller,
  output logic [6:0]                             out_level,
  output logic [1:0]                             out_source_control,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [actcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [actcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import actcd_pkg::*;

  localparam int IDX_W = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;
  // Entry layout: {filter, burst count, active, sent level, last send time}
  localparam int ENT_W    = SAMPLE_BITS + COUNT_W + 1 + LEVEL_W + TIME_W;
  localparam int LAST_LO  = 0;
  localparam int SENT_LO  = LAST_LO + TIME_W;
  localparam int ACT_POS  = SENT_LO + LEVEL_W;
  localparam int CNT_LO   = ACT_POS + 1;
  localparam int FILT_LO  = CNT_LO + COUNT_W;

  // Configuration registers
  logic [6:0]  deviation_r;
  logic [5:0]  clamp_r;
  logic [15:0] min_interval_r;
  logic [5:0]  extra_r;
  logic [6:0]  ctrl_a_r;
  logic [6:0]  ctrl_b_r;
  logic [6:0]  ctrl_c_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deviation_r    <= DEVIATION_RST;
      clamp_r        <= CLAMP_RST;
      min_interval_r <= MIN_INTERVAL_RST;
      extra_r        <= EXTRA_RST;
      ctrl_a_r       <= CTRL_A_RST;
      ctrl_b_r       <= CTRL_B_RST;
      ctrl_c_r       <= CTRL_C_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEVIATION:    deviation_r    <= cfg_data[6:0];
        CFG_CLAMP_RANGE:  clamp_r        <= cfg_data[5:0];
        CFG_MIN_INTERVAL: min_interval_r <= cfg_data[15:0];
        CFG_EXTRA:        extra_r        <= cfg_data[5:0];
        CFG_CTRL_A:       ctrl_a_r       <= cfg_data[6:0];
        CFG_CTRL_B:       ctrl_b_r       <= cfg_data[6:0];
        CFG_CTRL_C:       ctrl_c_r       <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic                   s1_valid_r;
  logic                   s1_op_r;
  logic [1:0]             s1_idx_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   out_valid_r;
  logic                   s1_hold;
  logic                   in_fire;
  logic                   s1_fire;

  // Hold the update stage only while it has work and the output is blocked
  assign s1_hold  = s1_valid_r && out_valid_r && out_stall;
  assign in_stall = s1_hold;
  assign in_fire  = in_valid && !s1_hold;
  assign s1_fire  = s1_valid_r && !s1_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_hold) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= in_op;
      s1_idx_r    <= in_control_index;
      s1_sample_r <= SAMPLE_BITS'(in_sample);
    end
  end

  // State memory and forwarding
  logic [IDX_W-1:0]        s1_addr;
  logic [ENT_W-1:0]        rd_data;
  logic [ENT_W-1:0]        wr_data;
  logic                    wr_en;
  logic [NUM_CONTROLS-1:0] valid_r;
  logic                    fwd_valid_r;
  logic [IDX_W-1:0]        fwd_addr_r;
  logic [ENT_W-1:0]        fwd_data_r;
  logic [ENT_W-1:0]        ent;

  assign s1_addr = IDX_W'(s1_idx_r);

  actcd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_CONTROLS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (IDX_W'(in_control_index)),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[s1_addr] <= 1'b1;
      end
      if (!s1_hold) begin
        fwd_valid_r <= wr_en;
      end
    end
  end

  // Keep the write that coincided with this request's read
  always_ff @(posedge clk) begin
    if (!s1_hold) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= wr_data;
    end
  end

  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_addr)) begin
      ent = fwd_data_r;
    end else if (valid_r[s1_addr]) begin
      ent = rd_data;
    end else begin
      ent = '0;
    end
  end

  // Update logic
  logic [TIME_W-1:0]      ms_r;
  logic [SAMPLE_BITS-1:0] filt;
  logic [COUNT_W-1:0]     cnt;
  logic                   act;
  logic [LEVEL_W-1:0]     sent;
  logic [TIME_W-1:0]      last;
  logic                   in_range;
  logic [SAMPLE_BITS:0]   sum;
  logic [COUNT_W-1:0]     cnt_inc;
  logic [SAMPLE_BITS-1:0] filt_nxt;
  logic [COUNT_W-1:0]     cnt_nxt;
  logic                   act_nxt;
  logic                   eval;
  logic [LEVEL_W-1:0]     raw_lvl;
  logic [LEVEL_W-1:0]     hi_lvl;
  logic [LEVEL_W-1:0]     lvl;
  logic [LEVEL_W-1:0]     diff;
  logic [TIME_W-1:0]      elapsed;
  logic                   send;
  logic [6:0]             ctrl_num;

  assign filt = ent[FILT_LO +: SAMPLE_BITS];
  assign cnt  = ent[CNT_LO +: COUNT_W];
  assign act  = ent[ACT_POS];
  assign sent = ent[SENT_LO +: LEVEL_W];
  assign last = ent[LAST_LO +: TIME_W];

  assign in_range = ({30'd0, s1_idx_r} < 32'(NUM_CONTROLS));
  assign sum      = {1'b0, filt} + {1'b0, s1_sample_r};
  assign cnt_inc  = cnt + 6'd1;

  always_comb begin
    if (!act) begin
      // First sample of a burst loads the filter
      filt_nxt = s1_sample_r;
      cnt_nxt  = '0;
      eval     = (extra_r == 6'd0);
      act_nxt  = !eval;
    end else begin
      filt_nxt = sum[SAMPLE_BITS:1];
      eval     = (cnt_inc >= extra_r);
      cnt_nxt  = eval ? '0 : cnt_inc;
      act_nxt  = !eval;
    end
  end

  assign raw_lvl = filt_nxt[SAMPLE_BITS-1 -: LEVEL_W];
  assign hi_lvl  = (raw_lvl >= (LEVEL_MAX - {1'b0, clamp_r})) ? LEVEL_MAX : raw_lvl;
  // Low clamp is applied last and wins on overlap
  assign lvl     = (hi_lvl <= {1'b0, clamp_r}) ? '0 : hi_lvl;
  assign diff    = (sent > lvl) ? (sent - lvl) : (lvl - sent);
  assign elapsed = ms_r - last;
  assign send    = eval && (diff >= deviation_r) && (elapsed >= 32'(min_interval_r));

  assign wr_en   = s1_fire && (s1_op_r == OP_SAMPLE) && in_range;
  assign wr_data = {filt_nxt, cnt_nxt, act_nxt,
                    send ? lvl : sent,
                    send ? ms_r : last};

  always_comb begin
    case (s1_idx_r)
      CONTROL_A: ctrl_num = ctrl_a_r;
      CONTROL_B: ctrl_num = ctrl_b_r;
      CONTROL_C: ctrl_num = ctrl_c_r;
      default:   ctrl_num = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r <= '0;
    end else if (s1_fire && (s1_op_r == OP_TICK)) begin
      ms_r <= ms_r + 32'd1;
    end
  end

  // Output register
  logic [6:0] out_ctrl_r;
  logic [6:0] out_lvl_r;
  logic [1:0] out_src_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wr_en && send) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && send) begin
      out_ctrl_r <= ctrl_num;
      out_lvl_r  <= lvl;
      out_src_r  <= s1_idx_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status_byte    = STATUS_CC;
  assign out_controller     = out_ctrl_r;
  assign out_level          = out_lvl_r;
  assign out_source_control = out_src_r;

endmodule

`default_nettype wire

[src/actcd_chk.sv]
`default_nettype none
`include "adc_to_control_change_deadband_top_defines.svh"

module actcd_chk #(
  parameter int NUM_CONTROLS = actcd_pkg::NUM_CONTROLS_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [7:0]                        out_status_byte,
  input wire logic [6:0]                        out_controller,
  input wire logic [6:0]                        out_level,
  input wire logic [1:0]                        out_source_control
);

  import actcd_pkg::*;

  // Every message is a control change
  `ACTCD_ASSERT_IMPL(a_status, out_valid, out_status_byte == STATUS_CC, "bad status byte")

  // Messages only come from controls that exist
  `ACTCD_ASSERT_IMPL(a_src_range, out_valid,
                     {30'd0, out_source_control} < 32'(NUM_CONTROLS), "source out of range")

  // Input backs up only behind a blocked message
  `ACTCD_ASSERT(a_stall_cause, !in_stall || (out_valid && out_stall), "stall without cause")

  // A blocked message holds
  `ACTCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                     out_valid && $stable(out_level) && $stable(out_controller)
                     && $stable(out_source_control), "blocked message changed")

endmodule

bind adc_to_control_change_deadband_top actcd_chk #(
  .NUM_CONTROLS (NUM_CONTROLS)
) u_actcd_chk (.*);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import actcd_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES  = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_REQS    = 165;

  localparam logic [1:0]           CONTROL_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 3'd7;

  typedef struct packed {
    logic        op;
    logic [1:0]  control;
    logic [11:0] sample;
  } slider_req_t;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] controller;
    logic [6:0] level;
    logic [1:0] source;
  } cc_msg_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_op = OP_SAMPLE;
  logic [1:0]            in_control_index = CONTROL_A;
  logic [11:0]           in_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_status_byte;
  logic [6:0]            out_controller;
  logic [6:0]            out_level;
  logic [1:0]            out_source_control;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DEVIATION;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register copies for prediction
  logic [6:0]  cur_deviation    = DEVIATION_RST;
  logic [5:0]  cur_clamp        = CLAMP_RST;
  logic [15:0] cur_min_interval = MIN_INTERVAL_RST;
  logic [5:0]  cur_extra        = EXTRA_RST;
  logic [6:0]  cc_number [3]    = '{CTRL_A_RST, CTRL_B_RST, CTRL_C_RST};

  // Per-control state for prediction
  logic [31:0] ms_now = '0;
  logic [11:0] filter_acc [3] = '{default: '0};
  logic [5:0]  burst_taken [3] = '{default: '0};
  logic        burst_open [3] = '{default: 1'b0};
  logic [6:0]  sent_level [3] = '{default: '0};
  logic [31:0] sent_time [3] = '{default: '0};

  slider_req_t pending_reqs [$];
  cc_msg_t     cc_expected [$];

  int error_count = 0;
  int req_count = 0;
  int tick_count = 0;
  int msg_count = 0;
  int setting_count = 0;
  int cycle_count = 0;

  logic hold_request = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   stall_mode = 0;
  int   pattern_left = 0;
  int   burst_left = 1;
  int   gap_left = 0;
  slider_req_t next_req;

  adc_to_control_change_deadband_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_control_index   (in_control_index),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status_byte    (out_status_byte),
    .out_controller     (out_controller),
    .out_level          (out_level),
    .out_source_control (out_source_control),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d messages still expected", $time, cc_expected.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_DEVIATION:    cur_deviation = data[6:0];
      CFG_CLAMP_RANGE:  cur_clamp = data[5:0];
      CFG_MIN_INTERVAL: cur_min_interval = data;
      CFG_EXTRA:        cur_extra = data[5:0];
      CFG_CTRL_A:       cc_number[CONTROL_A] = data[6:0];
      CFG_CTRL_B:       cc_number[CONTROL_B] = data[6:0];
      CFG_CTRL_C:       cc_number[CONTROL_C] = data[6:0];
      default: ;
    endcase
  endfunction

  // Scale, clamp, and rate-limit a finished burst
  function automatic void judge_burst(logic [1:0] ctl);
    logic [6:0]  lvl;
    logic [6:0]  diff;
    logic [31:0] elapsed;
    cc_msg_t     msg;
    lvl = filter_acc[ctl][11:5];
    if (lvl >= LEVEL_MAX - {1'b0, cur_clamp}) lvl = LEVEL_MAX;
    if (lvl <= {1'b0, cur_clamp}) lvl = '0;
    diff = (sent_level[ctl] > lvl) ? sent_level[ctl] - lvl : lvl - sent_level[ctl];
    elapsed = ms_now - sent_time[ctl];
    if (diff >= cur_deviation && elapsed >= {16'd0, cur_min_interval}) begin
      sent_time[ctl] = ms_now;
      sent_level[ctl] = lvl;
      msg.status = STATUS_CC;
      msg.controller = cc_number[ctl];
      msg.level = lvl;
      msg.source = ctl;
      cc_expected.push_back(msg);
    end
  endfunction

  function automatic void predict_cc(slider_req_t r);
    logic [12:0] sum;
    if (r.op == OP_TICK) begin
      ms_now = ms_now + 32'd1;
    end else if (r.control <= CONTROL_C) begin
      if (!burst_open[r.control]) begin
        filter_acc[r.control] = r.sample;
        burst_taken[r.control] = '0;
        if (cur_extra == '0) judge_burst(r.control);
        else burst_open[r.control] = 1'b1;
      end else begin
        sum = {1'b0, filter_acc[r.control]} + {1'b0, r.sample};
        filter_acc[r.control] = sum[12:1];
        burst_taken[r.control] = burst_taken[r.control] + 6'd1;
        if (burst_taken[r.control] >= cur_extra) begin
          burst_open[r.control] = 1'b0;
          burst_taken[r.control] = '0;
          judge_burst(r.control);
        end
      end
    end
  endfunction

  // Sender: bursts of requests with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_cc('{in_op, in_control_index, in_sample});
        req_count++;
        if (in_op == OP_TICK) tick_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_op <= next_req.op;
          in_control_index <= next_req.control;
          in_sample <= next_req.sample;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall patterns; one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (pattern_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        pattern_left = $urandom_range(5, 60);
      end else begin
        pattern_left = pattern_left - 1;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    cc_msg_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cc_expected.size() == 0) begin
        $display("%0t ns: unexpected message, expected none, got %0d %0d %0d %0d", $time,
                 out_status_byte, out_controller, out_level, out_source_control);
        error_count++;
      end else begin
        want = cc_expected.pop_front();
        check_field("status_byte", want.status, out_status_byte);
        check_field("controller", want.controller, out_controller);
        check_field("level", want.level, out_level);
        check_field("source_control", want.source, out_source_control);
        msg_count++;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    store_reg(idx, data);
    @(negedge clk);
  endtask

  // Fill unused upper data bits with junk on half the writes
  function automatic logic [CFG_DATA_W-1:0] pad(int unsigned value, int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 1) == 0) junk = '0;
    return (junk << width) | CFG_DATA_W'(value);
  endfunction

  task automatic set_config(int unsigned dev, int unsigned clamp, int unsigned interval,
                            int unsigned extra, int unsigned ca, int unsigned cb,
                            int unsigned cc);
    write_reg(CFG_DEVIATION, pad(dev, 7));
    write_reg(CFG_CLAMP_RANGE, pad(clamp, 6));
    write_reg(CFG_MIN_INTERVAL, CFG_DATA_W'(interval));
    write_reg(CFG_EXTRA, pad(extra, 6));
    write_reg(CFG_CTRL_A, pad(ca, 7));
    write_reg(CFG_CTRL_B, pad(cb, 7));
    write_reg(CFG_CTRL_C, pad(cc, 7));
    setting_count++;
  endtask

  task automatic queue_req(logic op, logic [1:0] ctl, int unsigned smp);
    pending_reqs.push_back('{op, ctl, 12'(smp)});
  endtask

  function automatic slider_req_t random_req();
    slider_req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.op = OP_SAMPLE;
    r.control = 2'($urandom_range(0, 2));
    r.sample = 12'($urandom_range(0, 4095));
    if (pick < 18) begin
      r.op = OP_TICK;
      r.control = 2'($urandom_range(0, 3));
    end else if (pick < 22) begin
      r.control = CONTROL_NONE;
    end else if (pick < 34) begin
      r.sample = 12'($urandom_range(0, 127));
    end else if (pick < 46) begin
      r.sample = 12'($urandom_range(3968, 4095));
    end
    return r;
  endfunction

  task automatic queue_random(int n, bit samples_only);
    slider_req_t r;
    int k;
    k = 0;
    while (k < n) begin
      r = random_req();
      if (samples_only) begin
        r.op = OP_SAMPLE;
        pending_reqs.push_back(r);
        k++;
      end else if ($urandom_range(0, 49) == 0) begin
        // a run of ticks to get past long send intervals
        repeat (12) begin
          r = random_req();
          r.op = OP_TICK;
          pending_reqs.push_back(r);
        end
        k += 12;
      end else begin
        pending_reqs.push_back(r);
        k++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pending_reqs.size() != 0 || in_valid || cc_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int ph;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every burst ends at once, every change sends
    write_reg(CFG_SPARE, 16'hFFFF);
    set_config(0, 0, 0, 0, 127, 0, 85);
    queue_req(OP_SAMPLE, CONTROL_A, 0);
    queue_req(OP_SAMPLE, CONTROL_B, 4095);
    queue_req(OP_SAMPLE, CONTROL_C, 4064);
    queue_req(OP_SAMPLE, CONTROL_A, 32);
    queue_req(OP_SAMPLE, CONTROL_A, 31);
    queue_req(OP_SAMPLE, CONTROL_B, 2048);
    queue_req(OP_SAMPLE, CONTROL_NONE, 4095);
    queue_req(OP_TICK, CONTROL_NONE, 4095);
    queue_req(OP_SAMPLE, CONTROL_C, 0);
    queue_req(OP_SAMPLE, CONTROL_C, 0);
    wait_idle();

    // Directed: widest clamp, full-swing deviation, interval blocking a send
    set_config(127, 63, 3, 1, 0, 127, 42);
    queue_req(OP_SAMPLE, CONTROL_A, 4095);
    queue_req(OP_SAMPLE, CONTROL_A, 4095);
    queue_req(OP_SAMPLE, CONTROL_A, 0);
    queue_req(OP_SAMPLE, CONTROL_A, 0);
    queue_req(OP_SAMPLE, CONTROL_B, 2048);
    queue_req(OP_SAMPLE, CONTROL_B, 2048);
    queue_req(OP_TICK, CONTROL_A, 0);
    queue_req(OP_TICK, CONTROL_B, 0);
    queue_req(OP_TICK, CONTROL_C, 0);
    queue_req(OP_SAMPLE, CONTROL_C, 4064);
    queue_req(OP_SAMPLE, CONTROL_C, 4064);
    wait_idle();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_config(0, 0, 0, 1, 0, 0, 0);
        1: set_config(127, 63, 0, 63, 127, 127, 127);
        2: set_config(2, 2, 10, 20, 1, 2, 3);
        3: set_config($urandom_range(0, 8), $urandom_range(0, 63), 65535, 3,
                      $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
        default: set_config($urandom_range(0, 10), $urandom_range(0, 63),
                            $urandom_range(0, 20), $urandom_range(0, 6),
                            $urandom_range(0, 127), $urandom_range(0, 127),
                            $urandom_range(0, 127));
      endcase
      queue_random(PHASE_REQS, 1'b0);
      wait_idle();
    end

    // Hold off the receiver while samples keep coming; all but those to no control send
    set_config(0, 0, 0, 0, $urandom_range(0, 127), $urandom_range(0, 127),
               $urandom_range(0, 127));
    hold_request = 1'b1;
    queue_random(100, 1'b1);
    wait_idle();
    hold_request = 1'b0;

    $display("Checked %0d control-change messages from %0d requests (%0d ticks)",
             msg_count, req_count, tick_count);
    $display("across %0d register settings, including a %0d-cycle receiver hold-off.",
             setting_count, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/actcd_pkg.sv
src/actcd_ram.sv
src/adc_to_control_change_deadband_top.sv
src/actcd_chk.sv
test/testbench.sv
